// ===== src/aging_keyed_cache_policy_unit_assert.svh =====
// Assertion macros for the aging keyed cache policy unit checker.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef AGING_KEYED_CACHE_POLICY_UNIT_ASSERT_SVH
`define AGING_KEYED_CACHE_POLICY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ACPU_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acpu check failed");

// Next-cycle implication, disabled during reset
`define ACPU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acpu check failed");

`endif

// ===== src/acpu_pkg.sv =====
// Shared types and constants of the aging keyed cache policy unit.
// Used by the controller, the datapath and the checker.
package acpu_pkg;

  // Request codes carried on the input tuser
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_SWEEP = 2'd2;

  // Configuration register indexes and reset values
  localparam int         CFG_IDX_W       = 4;
  localparam logic [3:0] REG_MAX_ENTRIES = 4'd0;
  localparam logic [3:0] REG_AGE_LIMIT   = 4'd1;
  localparam logic [3:0]  RST_MAX_ENTRIES = 4'd5;
  localparam logic [15:0] RST_AGE_LIMIT   = 16'd60;

  // Most expired entries reported by one sweep
  localparam int MAX_RESULTS = 8;
  localparam int SWEEP_W     = 4;

  typedef enum logic [2:0] {
    OUT_PUSH_OK     = 3'd0,
    OUT_PUSH_REJECT = 3'd1,
    OUT_POP_HIT     = 3'd2,
    OUT_POP_MISS    = 3'd3,
    OUT_EVICTED     = 3'd4,
    OUT_EXPIRED     = 3'd5,
    OUT_SWEEP_NONE  = 3'd6
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_INSERT,
    ST_SWEEP_LOAD,
    ST_SWEEP_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     rescan;
    logic     emit;
    outcome_t emit_kind;
    logic     emit_last;
    logic     ins_write;
    logic     clr_match;
    logic     clr_best;
    logic     sweep_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       scan_busy;
    logic       out_free;
    logic [1:0] req;
    logic       push_bad;
    logic       pop_hit;
    logic       match;
    logic       full;
    logic       best_found;
    logic       sweep_last;
  } sts_t;

endpackage

// ===== src/acpu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acpu_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/acpu_ctrl.sv =====
// Controller state machine of the aging keyed cache policy unit.
// Depends on acpu_pkg for the state, command and status types.
module acpu_ctrl import acpu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts.scan_busy) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (sts.req)
          REQ_PUSH: begin
            if (sts.push_bad) begin
              if (sts.out_free) state_next = ST_IDLE;
            end else if (!sts.match && sts.full) begin
              state_next = ST_EVICT;
            end else begin
              state_next = ST_INSERT;
            end
          end
          REQ_POP: begin
            if (sts.out_free) state_next = ST_IDLE;
          end
          REQ_SWEEP: begin
            if (sts.best_found) begin
              state_next = ST_SWEEP_LOAD;
            end else if (sts.out_free) begin
              state_next = ST_IDLE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_EVICT: begin
        if (sts.out_free) state_next = ST_INSERT;
      end
      ST_INSERT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      ST_SWEEP_LOAD: state_next = ST_SWEEP_EMIT;
      ST_SWEEP_EMIT: begin
        if (sts.out_free) state_next = sts.sweep_last ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.emit_kind = OUT_PUSH_OK;
    in_ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_SCAN: ;
      ST_DECIDE: begin
        unique case (sts.req)
          REQ_PUSH: begin
            if (sts.push_bad && sts.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = OUT_PUSH_REJECT;
              cmd.emit_last = 1'b1;
            end
          end
          REQ_POP: begin
            if (sts.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.emit_kind = sts.pop_hit ? OUT_POP_HIT : OUT_POP_MISS;
              cmd.clr_match = sts.pop_hit;
            end
          end
          REQ_SWEEP: begin
            if (!sts.best_found && sts.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = OUT_SWEEP_NONE;
              cmd.emit_last = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_EVICT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = OUT_EVICTED;
          cmd.clr_best  = 1'b1;
        end
      end
      ST_INSERT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = OUT_PUSH_OK;
          cmd.emit_last = 1'b1;
          cmd.ins_write = 1'b1;
        end
      end
      ST_SWEEP_LOAD: begin
        cmd.sweep_load = 1'b1;
      end
      ST_SWEEP_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = OUT_EXPIRED;
          cmd.emit_last = sts.sweep_last;
          cmd.clr_best  = 1'b1;
          cmd.rescan    = !sts.sweep_last;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/acpu_dp.sv =====
// Datapath of the aging keyed cache policy unit: slot store, scan, result register.
// Depends on acpu_pkg and acpu_ram.
module acpu_dp import acpu_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [1:0]           in_req,
  input  logic [31:0]          in_key,
  input  logic [31:0]          in_handle,
  input  logic [31:0]          in_now,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output outcome_t             out_kind,
  output logic [31:0]          out_key,
  output logic [31:0]          out_handle,
  output logic                 out_last
);

  localparam int            AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int            CW       = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [7:0]    CAP8     = 8'(CAPACITY);

  // Configuration
  logic [3:0]  max_entries;
  logic [15:0] age_limit;

  // Latched request
  logic [1:0]  req;
  logic [31:0] key;
  logic [31:0] hd;
  logic [31:0] now;

  logic [CAPACITY-1:0] valid;

  // Scan pipeline
  logic          scan_start;
  logic          issue_on;
  logic [AW-1:0] issue_idx;
  logic          rd_on;
  logic [AW-1:0] rd_idx;
  logic          scan_busy;
  logic [95:0]   rd_data;
  logic [31:0]   r_key;
  logic [31:0]   r_hd;
  logic [31:0]   r_stamp;
  logic          r_valid;
  logic [31:0]   r_age;
  logic          r_expired;
  logic          take_best;

  // Scan results
  logic          match_found;
  logic [AW-1:0] match_idx;
  logic [31:0]   match_handle;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          best_found;
  logic [AW-1:0] best_idx;
  logic [31:0]   best_key;
  logic [31:0]   best_handle;
  logic [31:0]   best_age;
  logic [CW-1:0] cnt_valid;
  logic [CW-1:0] exp_cnt;
  logic          evicted;
  logic [SWEEP_W-1:0] sweep_left;

  logic [AW-1:0] ins_idx;
  logic [7:0]    limit;

  assign scan_start = cmd.load | cmd.rescan;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= RST_MAX_ENTRIES;
      age_limit   <= RST_AGE_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_ENTRIES: max_entries <= cfg_data[3:0];
        REG_AGE_LIMIT:   age_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_req;
      key <= in_key;
      hd  <= in_handle;
      now <= in_now;
    end
  end

  // Pick the insert slot: refreshed entry, else first free slot after eviction
  always_comb begin
    if (match_found) begin
      ins_idx = match_idx;
    end else if (free_found && !(evicted && best_idx < free_idx)) begin
      ins_idx = free_idx;
    end else begin
      ins_idx = best_idx;
    end
  end

  acpu_ram #(
    .WIDTH (96),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (cmd.ins_write),
    .wr_addr (ins_idx),
    .wr_data ({now, hd, key}),
    .rd_en   (issue_on),
    .rd_addr (issue_idx),
    .rd_data (rd_data)
  );

  assign r_key     = rd_data[31:0];
  assign r_hd      = rd_data[63:32];
  assign r_stamp   = rd_data[95:64];
  assign r_valid   = valid[rd_idx];
  assign r_age     = now - r_stamp;
  assign r_expired = (r_age >= {16'd0, age_limit});

  // Oldest entry for a push, lowest expired key for a sweep
  always_comb begin
    if (req == REQ_SWEEP) begin
      take_best = r_valid && r_expired && (!best_found || r_key < best_key);
    end else begin
      take_best = r_valid && (!best_found || r_age > best_age ||
                              (r_age == best_age && r_key < best_key));
    end
  end

  // Walk the slots one read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_on  <= 1'b0;
      rd_on     <= 1'b0;
      scan_busy <= 1'b0;
    end else if (scan_start) begin
      issue_on  <= 1'b1;
      rd_on     <= 1'b0;
      scan_busy <= 1'b1;
    end else begin
      rd_on <= issue_on;
      if (issue_on && issue_idx == LAST_IDX) issue_on <= 1'b0;
      if (rd_on && rd_idx == LAST_IDX) scan_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      issue_idx <= '0;
    end else if (issue_on) begin
      issue_idx <= issue_idx + 1'b1;
    end
    rd_idx <= issue_idx;
  end

  // Accumulate match, free slot, counts and best candidate
  always_ff @(posedge clk) begin
    if (rst || scan_start) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      best_found  <= 1'b0;
      cnt_valid   <= '0;
      exp_cnt     <= '0;
    end else if (rd_on) begin
      if (r_valid) cnt_valid <= cnt_valid + 1'b1;
      if (r_valid && r_expired) exp_cnt <= exp_cnt + 1'b1;
      if (r_valid && r_key == key && !match_found) begin
        match_found  <= 1'b1;
        match_idx    <= rd_idx;
        match_handle <= r_hd;
      end
      if (!r_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (take_best) begin
        best_found  <= 1'b1;
        best_idx    <= rd_idx;
        best_key    <= r_key;
        best_handle <= r_hd;
        best_age    <= r_age;
      end
    end
  end

  // Slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.clr_match) valid[match_idx] <= 1'b0;
      if (cmd.clr_best) valid[best_idx] <= 1'b0;
      if (cmd.ins_write) valid[ins_idx] <= 1'b1;
    end
  end

  // Eviction mark
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      evicted <= 1'b0;
    end else if (cmd.clr_best) begin
      evicted <= 1'b1;
    end
  end

  // Load the budget on the first pass of a sweep only, hold it on rescans
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_left <= '0;
    end else if (cmd.sweep_load && sweep_left == '0) begin
      if (8'(exp_cnt) >= 8'(MAX_RESULTS)) begin
        sweep_left <= SWEEP_W'(MAX_RESULTS);
      end else begin
        sweep_left <= SWEEP_W'(exp_cnt);
      end
    end else if (cmd.emit && cmd.emit_kind == OUT_EXPIRED) begin
      sweep_left <= sweep_left - 1'b1;
    end
  end

  // Fill limit clamped to 1..CAPACITY
  always_comb begin
    if (max_entries == 4'd0) begin
      limit = 8'd1;
    end else if ({4'd0, max_entries} > CAP8) begin
      limit = CAP8;
    end else begin
      limit = {4'd0, max_entries};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind <= cmd.emit_kind;
      out_last <= cmd.emit_last;
      case (cmd.emit_kind) inside
        OUT_PUSH_OK, OUT_PUSH_REJECT, OUT_POP_MISS: begin
          out_key    <= key;
          out_handle <= '0;
        end
        OUT_POP_HIT: begin
          out_key    <= key;
          out_handle <= match_handle;
        end
        OUT_EVICTED, OUT_EXPIRED: begin
          out_key    <= best_key;
          out_handle <= best_handle;
        end
        default: begin
          out_key    <= '0;
          out_handle <= '0;
        end
      endcase
    end
  end

  // Status toward the controller
  always_comb begin
    sts.scan_busy  = scan_busy;
    sts.out_free   = !out_valid || out_ready;
    sts.req        = req;
    sts.push_bad   = (key == 32'd0) || (hd == 32'd0);
    sts.pop_hit    = (key != 32'd0) && match_found;
    sts.match      = match_found;
    sts.full       = (8'(cnt_valid) >= limit);
    sts.best_found = best_found;
    sts.sweep_last = (sweep_left == SWEEP_W'(1));
  end

endmodule

// ===== src/aging_keyed_cache_policy_unit.sv =====
// Aging keyed cache policy unit. Holds up to CAPACITY keyed handles with their
// stamps; a push refreshes or inserts (evicting the oldest entry when full), a
// pop removes a hit, a sweep reports and removes entries at or past the age
// limit in ascending key order. One request is worked on at a time and every
// pass walks the slot RAM one entry per cycle. A sweep that reports entries
// rescans the slots after each but the last and reports at most eight. Results
// wait in an output register; the next request is taken once the last result
// of a run is loaded, and a stalled output holds the controller in place.
// Depends on acpu_pkg, acpu_ctrl, acpu_dp and acpu_ram.
module aging_keyed_cache_policy_unit import acpu_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // Config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  // Request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,  // lookup_key, handle, now_seconds
  input  logic [1:0]           s_axis_tuser,  // req_type
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,  // out_key, out_handle
  output logic [2:0]           m_axis_tuser,  // outcome
  output logic                 m_axis_tlast   // last_of_run
);

  cmd_t     cmd;
  sts_t     sts;
  outcome_t out_kind;

  assign cfg_ready    = 1'b1;
  assign m_axis_tuser = out_kind;

  acpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  acpu_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_req     (s_axis_tuser),
    .in_key     (s_axis_tdata[31:0]),
    .in_handle  (s_axis_tdata[63:32]),
    .in_now     (s_axis_tdata[95:64]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (out_kind),
    .out_key    (m_axis_tdata[31:0]),
    .out_handle (m_axis_tdata[63:32]),
    .out_last   (m_axis_tlast)
  );

endmodule

// ===== src/acpu_checker.sv =====
// Port-level checks for the aging keyed cache policy unit, bound to the top level.
// Depends on acpu_pkg and aging_keyed_cache_policy_unit_assert.svh.
module acpu_checker import acpu_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

`include "aging_keyed_cache_policy_unit_assert.svh"

  // A stalled result beat holds
  `ACPU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // One request at a time: ready drops after an accepted beat
  `ACPU_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // An eviction result is never the last of its run; the insert result follows
  `ACPU_ASSERT_IMPLY(a_evict_not_last, m_axis_tvalid && m_axis_tuser == OUT_EVICTED, !m_axis_tlast)

  // An empty sweep is a lone zero result
  `ACPU_ASSERT_IMPLY(a_none_alone, m_axis_tvalid && m_axis_tuser == OUT_SWEEP_NONE, m_axis_tlast && m_axis_tdata == 64'd0)

  // Stored handles are never null
  `ACPU_ASSERT_IMPLY(a_hit_handle, m_axis_tvalid && m_axis_tuser == OUT_POP_HIT, m_axis_tdata[63:32] != 32'd0)

endmodule

bind aging_keyed_cache_policy_unit acpu_checker u_acpu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
